// File: rtl/core/vhvc_pkg.sv
package vhvc_pkg;

   localparam int MUL_W      = 32;
   localparam int LANE_W     = 16;
   localparam int HALF_W     = 16;
   localparam int DIFF_W     = 18;
   localparam int MAG_W      = 17;
   localparam int DD_W       = 34;
   localparam int AA_W       = 32;
   localparam int DOT_W      = 35;
   localparam int IDX_W      = 30;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;

   localparam logic [IDX_W-1:0] IDX_MAX = {IDX_W{1'b1}};

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_CAMS       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MASK_THRESHOLD = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SHAPE_KIND     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SHAPE_RELATION = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SHAPE_CENTER   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SHAPE_EXTENT   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SHAPE_RADIUS   = 3'd6;

   localparam logic [1:0] SHAPE_NONE     = 2'd0;
   localparam logic [1:0] SHAPE_CYLINDER = 2'd1;
   localparam logic [1:0] SHAPE_SPHERE   = 2'd2;
   localparam logic [1:0] SHAPE_BOX      = 2'd3;

   localparam logic [1:0] REL_INSIDE     = 2'd0;
   localparam logic [1:0] REL_BELOW      = 2'd1;
   localparam logic [1:0] REL_NEXT_BELOW = 2'd2;

   typedef struct packed {
      logic [1:0]            kind;
      logic [1:0]            relation;
      logic [3*LANE_W-1:0]   center;
      logic [3*LANE_W-1:0]   extent;
      logic [LANE_W-1:0]     radius;
   } shape_cfg_type;

   typedef struct packed {
      logic done;
      logic pass;
   } shape_status_type;

   typedef enum logic [2:0] {
      SH_IDLE,
      SH_PREP,
      SH_BOX,
      SH_MUL,
      SH_DONE
   } shape_state_type;

endpackage

// File: rtl/core/vhvc_mul.sv
module vhvc_mul
   import vhvc_pkg::*;
(
   input  logic               clock,
   input  logic [MUL_W-1:0]   mul_a,
   input  logic [MUL_W-1:0]   mul_b,
   output logic [2*MUL_W-1:0] mul_p
);

   logic [2*MUL_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= (2*MUL_W)'(mul_a) * (2*MUL_W)'(mul_b);
   end

   assign mul_p = prod_ff;

endmodule

// File: rtl/core/vhvc_shape.sv
module vhvc_shape
   import vhvc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               take,
   input  shape_cfg_type      cfg,
   input  logic [HALF_W-1:0]  pos_x,
   input  logic [HALF_W-1:0]  pos_y,
   input  logic [HALF_W-1:0]  pos_z,
   output shape_status_type   status
);

   localparam logic [3:0] STEP_DD0   = 4'd0;
   localparam logic [3:0] STEP_DD1   = 4'd1;
   localparam logic [3:0] STEP_DD2   = 4'd2;
   localparam logic [3:0] STEP_RR    = 4'd3;
   localparam logic [3:0] STEP_AA0   = 4'd4;
   localparam logic [3:0] STEP_AA1   = 4'd5;
   localparam logic [3:0] STEP_AA2   = 4'd6;
   localparam logic [3:0] STEP_DOT0  = 4'd7;
   localparam logic [3:0] STEP_DOT1  = 4'd8;
   localparam logic [3:0] STEP_DOT2  = 4'd9;
   localparam logic [3:0] STEP_DDAA  = 4'd10;
   localparam logic [3:0] STEP_R2AA  = 4'd11;
   localparam logic [3:0] STEP_DOTSQ = 4'd12;
   localparam logic [3:0] STEP_LHS   = 4'd13;
   localparam logic [3:0] STEP_CMP   = 4'd14;

   shape_state_type state_ff, state_in;
   logic [3:0]      step_ff, step_in;

   logic [HALF_W-1:0]        pos_ff  [3];
   logic [MAG_W-1:0]         dmag_ff [3];
   logic                     dneg_ff [3];
   logic [MAG_W-1:0]         emag_ff [3];
   logic                     eneg_ff [3];
   logic signed [DIFF_W-1:0] lo_ff   [3];
   logic signed [DIFF_W-1:0] hi_ff   [3];

   logic [DD_W-1:0]          dd_ff;
   logic [AA_W-1:0]          aa_ff;
   logic signed [DOT_W-1:0]  dot_ff;
   logic [AA_W-1:0]          r2_ff;
   logic [AA_W-1:0]          hiaa_ff;
   logic [2*MUL_W-1:0]       ddaa_ff;
   logic [2*MUL_W-1:0]       r2aa_ff;
   logic [2*MUL_W-1:0]       lhs_ff;
   logic [DD_W-1:0]          adot_ff;
   logic                     far_ff;
   logic                     near_ff;
   logic                     pneg_ff;
   logic                     pass_ff;

   logic signed [DIFF_W-1:0] pos_s [3];
   logic signed [DIFF_W-1:0] cen_s [3];
   logic signed [DIFF_W-1:0] ext_s [3];
   logic signed [DIFF_W-1:0] dif_s [3];
   logic                     ge_lo [3];
   logic                     le_hi [3];
   logic                     box_pass;

   logic [MUL_W-1:0]         mul_a, mul_b;
   logic                     mul_neg;
   logic [2*MUL_W-1:0]       prod;
   logic signed [DOT_W-1:0]  prod_s;

   vhvc_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (prod)
   );

   assign prod_s = signed'({1'b0, prod[DOT_W-2:0]});

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         pos_s[k] = signed'(DIFF_W'(pos_ff[k]));
         cen_s[k] = DIFF_W'(signed'(cfg.center[LANE_W*k +: LANE_W]));
         ext_s[k] = DIFF_W'(signed'(cfg.extent[LANE_W*k +: LANE_W]));
         dif_s[k] = pos_s[k] - cen_s[k];
         ge_lo[k] = pos_s[k] >= lo_ff[k];
         le_hi[k] = pos_s[k] <= hi_ff[k];
      end
   end

   always_comb begin
      case (cfg.relation)
         REL_INSIDE: begin
            box_pass = ge_lo[0] && ge_lo[1] && ge_lo[2] &&
                       le_hi[0] && le_hi[1] && le_hi[2];
         end
         REL_BELOW: begin
            box_pass = ge_lo[0] && !ge_lo[1] && ge_lo[2] && le_hi[0] && le_hi[2];
         end
         REL_NEXT_BELOW: begin
            box_pass = !ge_lo[1] ||
                       (le_hi[1] && (!ge_lo[0] || !le_hi[0] || !ge_lo[2] || !le_hi[2]));
         end
         default: begin
            box_pass = 1'b1;
         end
      endcase
   end

   // operand select for the shared multiplier
   always_comb begin
      mul_a   = '0;
      mul_b   = '0;
      mul_neg = 1'b0;
      if (state_ff == SH_MUL) begin
         case (step_ff)
            STEP_DD0, STEP_DD1, STEP_DD2: begin
               mul_a = MUL_W'(dmag_ff[step_ff[1:0]]);
               mul_b = MUL_W'(dmag_ff[step_ff[1:0]]);
            end
            STEP_RR: begin
               mul_a = MUL_W'(cfg.radius);
               mul_b = MUL_W'(cfg.radius);
            end
            STEP_AA0: begin
               mul_a = MUL_W'(emag_ff[0]);
               mul_b = MUL_W'(emag_ff[0]);
            end
            STEP_AA1: begin
               mul_a = MUL_W'(emag_ff[1]);
               mul_b = MUL_W'(emag_ff[1]);
            end
            STEP_AA2: begin
               mul_a = MUL_W'(emag_ff[2]);
               mul_b = MUL_W'(emag_ff[2]);
            end
            STEP_DOT0: begin
               mul_a   = MUL_W'(dmag_ff[0]);
               mul_b   = MUL_W'(emag_ff[0]);
               mul_neg = dneg_ff[0] ^ eneg_ff[0];
            end
            STEP_DOT1: begin
               mul_a   = MUL_W'(dmag_ff[1]);
               mul_b   = MUL_W'(emag_ff[1]);
               mul_neg = dneg_ff[1] ^ eneg_ff[1];
            end
            STEP_DOT2: begin
               mul_a   = MUL_W'(dmag_ff[2]);
               mul_b   = MUL_W'(emag_ff[2]);
               mul_neg = dneg_ff[2] ^ eneg_ff[2];
            end
            STEP_DDAA: begin
               mul_a = dd_ff[MUL_W-1:0];
               mul_b = aa_ff;
            end
            STEP_R2AA: begin
               mul_a = r2_ff;
               mul_b = aa_ff;
            end
            STEP_DOTSQ: begin
               mul_a = adot_ff[MUL_W-1:0];
               mul_b = adot_ff[MUL_W-1:0];
            end
            default: begin
               mul_a = '0;
               mul_b = '0;
            end
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = '0;
      case (state_ff)
         SH_IDLE: begin
            if (start) begin
               state_in = SH_PREP;
            end
         end
         SH_PREP: begin
            if (cfg.kind == SHAPE_NONE) begin
               state_in = SH_DONE;
            end else if (cfg.kind == SHAPE_BOX) begin
               state_in = SH_BOX;
            end else if (cfg.relation != REL_INSIDE) begin
               state_in = SH_DONE;
            end else begin
               state_in = SH_MUL;
            end
         end
         SH_BOX: begin
            state_in = SH_DONE;
         end
         SH_MUL: begin
            if ((cfg.kind == SHAPE_SPHERE && step_ff == STEP_AA0) || step_ff == STEP_CMP) begin
               state_in = SH_DONE;
            end else begin
               step_in = step_ff + 4'd1;
            end
         end
         SH_DONE: begin
            if (take) begin
               state_in = SH_IDLE;
            end
         end
         default: begin
            state_in = SH_IDLE;
         end
      endcase
   end

   always_comb begin
      status.done = (state_ff == SH_DONE);
      status.pass = pass_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SH_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // each step consumes the product issued in the previous step
   always_ff @(posedge clock) begin
      pneg_ff <= mul_neg;
      case (state_ff)
         SH_IDLE: begin
            if (start) begin
               pos_ff[0] <= pos_x;
               pos_ff[1] <= pos_y;
               pos_ff[2] <= pos_z;
            end
         end
         SH_PREP: begin
            pass_ff <= 1'b1;
            for (int k = 0; k < 3; k++) begin
               dneg_ff[k] <= dif_s[k][DIFF_W-1];
               dmag_ff[k] <= dif_s[k][DIFF_W-1] ? MAG_W'(-dif_s[k]) : MAG_W'(dif_s[k]);
               eneg_ff[k] <= ext_s[k][DIFF_W-1];
               emag_ff[k] <= ext_s[k][DIFF_W-1] ? MAG_W'(-ext_s[k]) : MAG_W'(ext_s[k]);
               lo_ff[k]   <= cen_s[k] - ext_s[k];
               hi_ff[k]   <= cen_s[k] + ext_s[k];
            end
         end
         SH_BOX: begin
            pass_ff <= box_pass;
         end
         SH_MUL: begin
            case (step_ff)
               STEP_DD1: begin
                  dd_ff <= prod[DD_W-1:0];
               end
               STEP_DD2, STEP_RR: begin
                  dd_ff <= dd_ff + prod[DD_W-1:0];
               end
               STEP_AA0: begin
                  r2_ff   <= prod[AA_W-1:0];
                  pass_ff <= dd_ff <= DD_W'(prod[AA_W-1:0]);
               end
               STEP_AA1: begin
                  aa_ff   <= prod[AA_W-1:0];
                  near_ff <= dd_ff < DD_W'(r2_ff);
               end
               STEP_AA2, STEP_DOT0: begin
                  aa_ff <= aa_ff + prod[AA_W-1:0];
               end
               STEP_DOT1: begin
                  dot_ff  <= pneg_ff ? -prod_s : prod_s;
                  hiaa_ff <= (dd_ff[DD_W-1] ? {aa_ff[AA_W-2:0], 1'b0} : '0) +
                             (dd_ff[DD_W-2] ? aa_ff : '0);
               end
               STEP_DOT2, STEP_DDAA: begin
                  dot_ff <= pneg_ff ? dot_ff - prod_s : dot_ff + prod_s;
               end
               STEP_R2AA: begin
                  ddaa_ff <= prod + {hiaa_ff, {MUL_W{1'b0}}};
                  adot_ff <= dot_ff[DOT_W-1] ? DD_W'(-dot_ff) : DD_W'(dot_ff);
               end
               STEP_DOTSQ: begin
                  r2aa_ff <= prod;
                  far_ff  <= adot_ff > DD_W'(aa_ff);
               end
               STEP_LHS: begin
                  lhs_ff <= ddaa_ff - prod;
               end
               STEP_CMP: begin
                  pass_ff <= (aa_ff == '0) ? near_ff : (!far_ff && lhs_ff < r2aa_ff);
               end
               default: begin
                  pass_ff <= pass_ff;
               end
            endcase
         end
         default: begin
            pass_ff <= pass_ff;
         end
      endcase
   end

endmodule

// File: rtl/core/visual_hull_voxel_classify.sv
// Shape test: none, a box compare, or a sphere or cylinder test; the cylinder test runs 13
// products in sequence through one shared 32x32 multiplier. A new word is taken only once
// the previous result has moved to the output register; a waiting result does not block
// the next word.
// Reset: synchronous, active high; control and configuration registers return to their
// defaults and the index counter returns to zero.
module visual_hull_voxel_classify
   import vhvc_pkg::*;
#(
   parameter int NUM_CAMS   = 8,
   parameter int COORD_BITS = 10
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_start_of_pass,
   input  logic [COORD_BITS-1:0]   req_pos_x,
   input  logic [COORD_BITS-1:0]   req_pos_y,
   input  logic [COORD_BITS-1:0]   req_pos_z,
   input  logic [NUM_CAMS-1:0]     req_seen_mask,
   input  logic [NUM_CAMS-1:0]     req_black_mask,
   input  logic                    req_is_fluid,
   input  logic                    req_is_source,
   input  logic signed [15:0]      req_mask_value,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_in_hull,
   output logic [IDX_W-1:0]        rsp_voxel_index,
   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   localparam int CNT_W = $clog2(NUM_CAMS + 1);

   logic [3:0]        min_cams_ff;
   logic [15:0]       mask_threshold_ff;
   shape_cfg_type     shape_cfg_ff;

   logic              busy_ff;
   logic              basic_ok_ff;
   logic              sop_ff;
   logic [IDX_W-1:0]  next_index_ff;
   logic              rsp_valid_ff;
   logic              rsp_in_hull_ff;
   logic [IDX_W-1:0]  rsp_voxel_index_ff;

   logic              accept;
   logic              take;
   logic [CNT_W-1:0]  cam_count;
   logic [16:0]       mask_mag;
   logic              mask_fail;
   logic              basic_ok;
   logic              hull;
   logic [IDX_W-1:0]  idx_base;
   shape_status_type  shape_status;

   vhvc_shape u_shape (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .take   (take),
      .cfg    (shape_cfg_ff),
      .pos_x  (HALF_W'({req_pos_x, 1'b1})),
      .pos_y  (HALF_W'({req_pos_y, 1'b1})),
      .pos_z  (HALF_W'({req_pos_z, 1'b1})),
      .status (shape_status)
   );

   assign req_ready       = !busy_ff;
   assign accept          = req_valid && req_ready;
   assign take            = shape_status.done && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_in_hull     = rsp_in_hull_ff;
   assign rsp_voxel_index = rsp_voxel_index_ff;

   always_comb begin
      cam_count = '0;
      for (int i = 0; i < NUM_CAMS; i++) begin
         cam_count = cam_count + CNT_W'(req_seen_mask[i]);
      end
   end

   always_comb begin
      mask_mag  = req_mask_value[15] ? (17'd0 - {req_mask_value[15], req_mask_value})
                                     : {1'b0, req_mask_value};
      mask_fail = (mask_threshold_ff != '0) && (mask_mag < {1'b0, mask_threshold_ff});
      basic_ok  = !(|req_black_mask) &&
                  (32'(cam_count) >= 32'(min_cams_ff)) &&
                  req_is_fluid && !req_is_source && !mask_fail;
      hull      = basic_ok_ff && shape_status.pass;
      idx_base  = sop_ff ? '0 : next_index_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_cams_ff       <= 4'd1;
         mask_threshold_ff <= '0;
         shape_cfg_ff      <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MIN_CAMS:       min_cams_ff           <= csr_wdata[3:0];
            CSR_MASK_THRESHOLD: mask_threshold_ff     <= csr_wdata[15:0];
            CSR_SHAPE_KIND:     shape_cfg_ff.kind     <= csr_wdata[1:0];
            CSR_SHAPE_RELATION: shape_cfg_ff.relation <= csr_wdata[1:0];
            CSR_SHAPE_CENTER:   shape_cfg_ff.center   <= csr_wdata[3*LANE_W-1:0];
            CSR_SHAPE_EXTENT:   shape_cfg_ff.extent   <= csr_wdata[3*LANE_W-1:0];
            CSR_SHAPE_RADIUS:   shape_cfg_ff.radius   <= csr_wdata[LANE_W-1:0];
            default: begin
               min_cams_ff <= min_cams_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         next_index_ff <= '0;
      end else begin
         if (accept) begin
            busy_ff <= 1'b1;
         end else if (take) begin
            busy_ff <= 1'b0;
         end
         if (take) begin
            rsp_valid_ff <= 1'b1;
            if (hull && idx_base != IDX_MAX) begin
               next_index_ff <= idx_base + IDX_W'(1);
            end else begin
               next_index_ff <= idx_base;
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         basic_ok_ff <= basic_ok;
         sop_ff      <= req_start_of_pass;
      end
      if (take) begin
         rsp_in_hull_ff     <= hull;
         rsp_voxel_index_ff <= hull ? idx_base : '0;
      end
   end

endmodule

// File: bench/visual_hull_voxel_classify_checker.sv
module visual_hull_voxel_classify_checker
   import vhvc_pkg::*;
#(
   parameter int NUM_CAMS   = 8,
   parameter int COORD_BITS = 10
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  logic                    req_start_of_pass,
   input  logic [COORD_BITS-1:0]   req_pos_x,
   input  logic [COORD_BITS-1:0]   req_pos_y,
   input  logic [COORD_BITS-1:0]   req_pos_z,
   input  logic [NUM_CAMS-1:0]     req_seen_mask,
   input  logic [NUM_CAMS-1:0]     req_black_mask,
   input  logic                    req_is_fluid,
   input  logic                    req_is_source,
   input  logic signed [15:0]      req_mask_value,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  logic                    rsp_in_hull,
   input  logic [IDX_W-1:0]        rsp_voxel_index,
   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata,
   output int                      fail_count,
   output int                      outstanding
);

   typedef struct {
      bit             in_hull;
      bit [IDX_W-1:0] voxel_index;
   } hull_result_type;

   bit [3:0]            min_cams_q;
   bit [15:0]           threshold_q;
   bit [1:0]            kind_q;
   bit [1:0]            relation_q;
   bit [3*LANE_W-1:0]   center_q;
   bit [3*LANE_W-1:0]   extent_q;
   bit [LANE_W-1:0]     radius_q;
   bit [IDX_W-1:0]      dense_index;

   hull_result_type     predicted_q[$];
   hull_result_type     want;
   int                  faults = 0;

   function automatic bit shape_pass(longint p[3]);
      longint    c[3];
      longint    e[3];
      longint    d[3];
      longint    lo[3];
      longint    hi[3];
      longint    dot;
      longint    adot;
      bit [63:0] dd;
      bit [63:0] aa;
      bit [63:0] r2;
      bit [63:0] dotsq;
      bit [63:0] lhs;
      dd  = 0;
      aa  = 0;
      dot = 0;
      for (int k = 0; k < 3; k++) begin
         c[k]  = longint'($signed(center_q[LANE_W*k +: LANE_W]));
         e[k]  = longint'($signed(extent_q[LANE_W*k +: LANE_W]));
         d[k]  = p[k] - c[k];
         lo[k] = c[k] - e[k];
         hi[k] = c[k] + e[k];
      end
      if (kind_q == SHAPE_NONE)
         return 1'b1;
      if (kind_q == SHAPE_CYLINDER || kind_q == SHAPE_SPHERE) begin
         if (relation_q != REL_INSIDE)
            return 1'b1;
         r2 = 64'(radius_q) * 64'(radius_q);
         for (int k = 0; k < 3; k++) begin
            dd  += 64'(d[k] * d[k]);
            aa  += 64'(e[k] * e[k]);
            dot += d[k] * e[k];
         end
         if (kind_q == SHAPE_SPHERE)
            return dd <= r2;
         if (aa == 0)
            return dd < r2;
         adot = (dot < 0) ? -dot : dot;
         if (64'(adot) > aa)
            return 1'b0;
         dotsq = 64'(adot) * 64'(adot);
         lhs   = dd * aa - dotsq;
         return lhs < r2 * aa;
      end
      case (relation_q)
         REL_INSIDE: begin
            return p[0] >= lo[0] && p[1] >= lo[1] && p[2] >= lo[2] &&
                   p[0] <= hi[0] && p[1] <= hi[1] && p[2] <= hi[2];
         end
         REL_BELOW: begin
            return p[0] >= lo[0] && p[1] < lo[1] && p[2] >= lo[2] &&
                   p[0] <= hi[0] && p[2] <= hi[2];
         end
         REL_NEXT_BELOW: begin
            return p[1] < lo[1] ||
                   (p[1] <= hi[1] &&
                    (p[0] < lo[0] || p[0] > hi[0] || p[2] < lo[2] || p[2] > hi[2]));
         end
         default: begin
            return 1'b1;
         end
      endcase
   endfunction

   function automatic hull_result_type classify_voxel(
      bit sop, bit [COORD_BITS-1:0] x, bit [COORD_BITS-1:0] y, bit [COORD_BITS-1:0] z,
      bit [NUM_CAMS-1:0] seen, bit [NUM_CAMS-1:0] black, bit fluid, bit src,
      bit signed [15:0] mask);
      hull_result_type r;
      longint          p[3];
      longint          mv;
      longint          mag;
      bit              ok;
      if (sop)
         dense_index = '0;
      mv   = longint'(mask);
      mag  = (mv < 0) ? -mv : mv;
      p[0] = longint'(x) * 2 + 1;
      p[1] = longint'(y) * 2 + 1;
      p[2] = longint'(z) * 2 + 1;
      ok = (black == '0) && ($countones(seen) >= int'(min_cams_q)) && fluid && !src &&
           !(threshold_q != 0 && mag < longint'(threshold_q)) && shape_pass(p);
      if (ok) begin
         r.in_hull     = 1'b1;
         r.voxel_index = dense_index;
         if (dense_index != IDX_MAX)
            dense_index++;
      end else begin
         r.in_hull     = 1'b0;
         r.voxel_index = '0;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         min_cams_q  <= 4'd1;
         threshold_q <= '0;
         kind_q      <= SHAPE_NONE;
         relation_q  <= REL_INSIDE;
         center_q    <= '0;
         extent_q    <= '0;
         radius_q    <= '0;
         dense_index = '0;
         predicted_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_MIN_CAMS:       min_cams_q  <= csr_wdata[3:0];
               CSR_MASK_THRESHOLD: threshold_q <= csr_wdata[15:0];
               CSR_SHAPE_KIND:     kind_q      <= csr_wdata[1:0];
               CSR_SHAPE_RELATION: relation_q  <= csr_wdata[1:0];
               CSR_SHAPE_CENTER:   center_q    <= csr_wdata[3*LANE_W-1:0];
               CSR_SHAPE_EXTENT:   extent_q    <= csr_wdata[3*LANE_W-1:0];
               CSR_SHAPE_RADIUS:   radius_q    <= csr_wdata[LANE_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (predicted_q.size() == 0) begin
               $display("%0t: unexpected result word in_hull %0d voxel_index %0d",
                        $time, rsp_in_hull, rsp_voxel_index);
               faults++;
            end else begin
               want = predicted_q.pop_front();
               if (rsp_in_hull !== want.in_hull) begin
                  $display("%0t: in_hull expected %0d actual %0d",
                           $time, want.in_hull, rsp_in_hull);
                  faults++;
               end
               if (rsp_voxel_index !== want.voxel_index) begin
                  $display("%0t: voxel_index expected %0d actual %0d",
                           $time, want.voxel_index, rsp_voxel_index);
                  faults++;
               end
            end
         end
         if (req_valid && req_ready)
            predicted_q.insert(predicted_q.size(),
                               classify_voxel(req_start_of_pass, req_pos_x, req_pos_y,
                                              req_pos_z, req_seen_mask, req_black_mask,
                                              req_is_fluid, req_is_source,
                                              req_mask_value));
      end
      outstanding <= predicted_q.size();
      fail_count  <= faults;
   end

endmodule

// File: bench/visual_hull_voxel_classify_tb.sv
module visual_hull_voxel_classify_tb;
   import vhvc_pkg::*;

   localparam int NUM_CAMS     = 8;
   localparam int COORD_BITS   = 10;
   localparam int LIMIT        = 400000;
   localparam int PHASES       = 25;
   localparam int PHASE_LEN    = 50;
   localparam int RSP_HOLD_LEN = 300;

   localparam logic [1:0] REL_UNDEFINED = 2'd3;

   logic                    clock;
   logic                    reset             = 1'b1;
   logic                    req_valid         = 1'b0;
   logic                    req_ready;
   logic                    req_start_of_pass = 1'b0;
   logic [COORD_BITS-1:0]   req_pos_x         = '0;
   logic [COORD_BITS-1:0]   req_pos_y         = '0;
   logic [COORD_BITS-1:0]   req_pos_z         = '0;
   logic [NUM_CAMS-1:0]     req_seen_mask     = '0;
   logic [NUM_CAMS-1:0]     req_black_mask    = '0;
   logic                    req_is_fluid      = 1'b0;
   logic                    req_is_source     = 1'b0;
   logic signed [15:0]      req_mask_value    = '0;
   logic                    rsp_valid;
   logic                    rsp_ready         = 1'b0;
   logic                    rsp_in_hull;
   logic [IDX_W-1:0]        rsp_voxel_index;
   logic                    csr_we            = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index         = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata         = '0;

   int                      fail_count;
   int                      outstanding;
   int                      cycles        = 0;
   int                      req_idle_pct  = 27;
   int                      rsp_idle_pct  = 27;
   int                      hold_req      = 0;

   int                      min_v;
   int                      thr_v;
   logic [1:0]              kind_v;
   logic [1:0]              rel_v;
   int                      cen_v[3];
   int                      ext_v[3];
   int                      rad_v;

   visual_hull_voxel_classify #(
      .NUM_CAMS   (NUM_CAMS),
      .COORD_BITS (COORD_BITS)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_start_of_pass (req_start_of_pass),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_pos_z         (req_pos_z),
      .req_seen_mask     (req_seen_mask),
      .req_black_mask    (req_black_mask),
      .req_is_fluid      (req_is_fluid),
      .req_is_source     (req_is_source),
      .req_mask_value    (req_mask_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_in_hull       (rsp_in_hull),
      .rsp_voxel_index   (rsp_voxel_index),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   visual_hull_voxel_classify_checker #(
      .NUM_CAMS   (NUM_CAMS),
      .COORD_BITS (COORD_BITS)
   ) i_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_start_of_pass (req_start_of_pass),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_pos_z         (req_pos_z),
      .req_seen_mask     (req_seen_mask),
      .req_black_mask    (req_black_mask),
      .req_is_fluid      (req_is_fluid),
      .req_is_source     (req_is_source),
      .req_mask_value    (req_mask_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_in_hull       (rsp_in_hull),
      .rsp_voxel_index   (rsp_voxel_index),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .fail_count        (fail_count),
      .outstanding       (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      while (cycles < LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("visual_hull_voxel_classify test failed");
      $finish;
   end

   // receiver: random stalls, plus a long hold-off when requested
   initial begin
      int hold_seen;
      int hold_left;
      hold_seen = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = RSP_HOLD_LEN;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   function automatic logic [CSR_DATA_W-1:0] pack3(int x, int y, int z);
      return {16'(z), 16'(y), 16'(x)};
   endfunction

   task automatic offer_voxel(logic sop, logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y,
                              logic [COORD_BITS-1:0] z, logic [NUM_CAMS-1:0] seen,
                              logic [NUM_CAMS-1:0] black, logic fluid, logic src,
                              logic [15:0] mask);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_start_of_pass <= sop;
      req_pos_x         <= x;
      req_pos_y         <= y;
      req_pos_z         <= z;
      req_seen_mask     <= seen;
      req_black_mask    <= black;
      req_is_fluid      <= fluid;
      req_is_source     <= src;
      req_mask_value    <= mask;
      do @(posedge clock); while (!req_ready);
   endtask

   // drop valid and wait for every outstanding word to come back
   task automatic drain;
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic write_all;
      write_reg(CSR_MIN_CAMS, CSR_DATA_W'(min_v));
      write_reg(CSR_MASK_THRESHOLD, CSR_DATA_W'(thr_v));
      write_reg(CSR_SHAPE_KIND, CSR_DATA_W'(kind_v));
      write_reg(CSR_SHAPE_RELATION, CSR_DATA_W'(rel_v));
      write_reg(CSR_SHAPE_CENTER, pack3(cen_v[0], cen_v[1], cen_v[2]));
      write_reg(CSR_SHAPE_EXTENT, pack3(ext_v[0], ext_v[1], ext_v[2]));
      write_reg(CSR_SHAPE_RADIUS, CSR_DATA_W'(rad_v));
      csr_we <= 1'b0;
   endtask

   task automatic pick_settings(int ph);
      int r;
      case (ph)
         0: begin
            min_v = 0; thr_v = 65535; kind_v = SHAPE_NONE; rel_v = REL_INSIDE; rad_v = 0;
            cen_v = '{0, 0, 0}; ext_v = '{0, 0, 0};
         end
         1: begin
            min_v = 15; thr_v = 1; kind_v = SHAPE_SPHERE; rel_v = REL_UNDEFINED; rad_v = 65535;
            cen_v = '{-32768, -32768, -32768}; ext_v = '{32767, 32767, 32767};
         end
         2: begin
            min_v = 8; thr_v = 0; kind_v = SHAPE_BOX; rel_v = REL_INSIDE; rad_v = 0;
            cen_v = '{1024, 1024, 1024}; ext_v = '{32767, 32767, 32767};
         end
         3: begin
            min_v = 1; thr_v = 0; kind_v = SHAPE_CYLINDER; rel_v = REL_INSIDE; rad_v = 65535;
            cen_v = '{32767, 32767, 32767}; ext_v = '{-32768, -32768, -32768};
         end
         default: begin
            kind_v = 2'($urandom_range(3));
            rel_v  = ($urandom_range(9) == 0) ? REL_UNDEFINED : 2'($urandom_range(2));
            if ((kind_v == SHAPE_CYLINDER || kind_v == SHAPE_SPHERE) && $urandom_range(3) != 0)
               rel_v = REL_INSIDE;
            min_v = ($urandom_range(12) == 0) ? $urandom_range(15, 9) : $urandom_range(8);
            if ($urandom_range(1) == 0)
               thr_v = 0;
            else
               thr_v = ($urandom_range(7) == 0) ? $urandom_range(65535) : $urandom_range(4096);
            for (int k = 0; k < 3; k++) begin
               r = $urandom_range(15);
               cen_v[k] = (r == 0) ? -32768 : (r == 1) ? 32767 : $urandom_range(2047);
               r = $urandom_range(15);
               ext_v[k] = (r == 0) ? -32768 : (r == 1) ? 32767 : (r < 4) ? 0 :
                          $urandom_range(400) - 200;
            end
            r = $urandom_range(15);
            rad_v = (r == 0) ? 65535 : (r == 1) ? 0 : $urandom_range(600);
         end
      endcase
      write_all();
   endtask

   function automatic logic [COORD_BITS-1:0] near_index(int c, int w);
      int h;
      h = c - w + $urandom_range(2 * w);
      if (h < 0)
         return '0;
      if (h / 2 > 1023)
         return '1;
      return COORD_BITS'(h / 2);
   endfunction

   task automatic random_voxel;
      logic [COORD_BITS-1:0] p[3];
      logic [NUM_CAMS-1:0]   seen;
      logic [15:0]           mask;
      int                    w;
      int                    m;
      for (int k = 0; k < 3; k++) begin
         w = rad_v + ((ext_v[k] < 0) ? -ext_v[k] : ext_v[k]) + 16;
         if (w > 4000)
            w = 4000;
         p[k] = ($urandom_range(9) < 7) ? near_index(cen_v[k], w) : COORD_BITS'($urandom);
      end
      if ($urandom_range(99) < 75) begin
         seen = '1 & ~(NUM_CAMS'(1) << $urandom_range(NUM_CAMS - 1));
         if ($urandom_range(1) == 0)
            seen = seen & NUM_CAMS'($urandom);
         if (thr_v > 0 && $urandom_range(1) == 0) begin
            m = thr_v + $urandom_range(64) - 32;
            if (m > 32768)
               m = 32768;
            if (m < 0)
               m = 0;
            mask = ($urandom_range(1) == 0) ? 16'(-m) : 16'(m);
         end else begin
            mask = 16'($urandom);
         end
         offer_voxel($urandom_range(49) == 0, p[0], p[1], p[2], seen, '0, 1'b1, 1'b0, mask);
      end else begin
         offer_voxel(1'($urandom), p[0], p[1], p[2], NUM_CAMS'($urandom), NUM_CAMS'($urandom),
                     1'($urandom), 1'($urandom), 16'($urandom));
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: one camera needed, no mask test, no shape
      offer_voxel(1'b1, 10'd0, 10'd0, 10'd0, 8'h01, 8'h00, 1'b1, 1'b0, 16'h0000);
      offer_voxel(1'b0, 10'd1023, 10'd1023, 10'd1023, 8'hFF, 8'h00, 1'b1, 1'b0, 16'h7FFF);
      offer_voxel(1'b0, 10'd5, 10'd5, 10'd5, 8'h00, 8'h00, 1'b1, 1'b0, 16'h0100);
      offer_voxel(1'b0, 10'd5, 10'd5, 10'd5, 8'h01, 8'h01, 1'b1, 1'b0, 16'h0100);
      offer_voxel(1'b0, 10'd5, 10'd5, 10'd5, 8'hFF, 8'h80, 1'b1, 1'b0, 16'h0100);
      offer_voxel(1'b0, 10'd5, 10'd5, 10'd5, 8'hFF, 8'h00, 1'b0, 1'b0, 16'h0100);
      offer_voxel(1'b0, 10'd5, 10'd5, 10'd5, 8'hFF, 8'h00, 1'b1, 1'b1, 16'h0100);
      offer_voxel(1'b0, 10'd5, 10'd5, 10'd5, 8'hFF, 8'h00, 1'b1, 1'b0, 16'h8000);
      offer_voxel(1'b1, 10'd5, 10'd5, 10'd5, 8'hFF, 8'h00, 1'b1, 1'b0, 16'h0100);
      drain();

      min_v = 8; thr_v = 32768; kind_v = SHAPE_NONE; rel_v = REL_INSIDE; rad_v = 0;
      cen_v = '{0, 0, 0}; ext_v = '{0, 0, 0};
      write_all();
      offer_voxel(1'b0, 10'd5, 10'd5, 10'd5, 8'hFF, 8'h00, 1'b1, 1'b0, 16'h8000);
      offer_voxel(1'b0, 10'd5, 10'd5, 10'd5, 8'hFF, 8'h00, 1'b1, 1'b0, 16'h7FFF);
      offer_voxel(1'b0, 10'd5, 10'd5, 10'd5, 8'h7F, 8'h00, 1'b1, 1'b0, 16'h8000);
      drain();

      min_v = 0; thr_v = 0; kind_v = SHAPE_SPHERE; rad_v = 20; cen_v = '{101, 101, 101};
      write_all();
      offer_voxel(1'b0, 10'd50, 10'd50, 10'd50, 8'h00, 8'h00, 1'b1, 1'b0, 16'h0000);
      offer_voxel(1'b0, 10'd60, 10'd50, 10'd50, 8'h00, 8'h00, 1'b1, 1'b0, 16'h0000);
      offer_voxel(1'b0, 10'd61, 10'd50, 10'd50, 8'h00, 8'h00, 1'b1, 1'b0, 16'h0000);
      drain();

      kind_v = SHAPE_CYLINDER;
      write_all();
      offer_voxel(1'b0, 10'd60, 10'd50, 10'd50, 8'h00, 8'h00, 1'b1, 1'b0, 16'h0000);
      offer_voxel(1'b0, 10'd59, 10'd50, 10'd50, 8'h00, 8'h00, 1'b1, 1'b0, 16'h0000);
      drain();

      ext_v = '{0, 40, 0}; rad_v = 10;
      write_all();
      offer_voxel(1'b0, 10'd50, 10'd70, 10'd50, 8'h00, 8'h00, 1'b1, 1'b0, 16'h0000);
      offer_voxel(1'b0, 10'd50, 10'd71, 10'd50, 8'h00, 8'h00, 1'b1, 1'b0, 16'h0000);
      drain();

      rel_v = REL_BELOW;
      write_all();
      offer_voxel(1'b0, 10'd900, 10'd900, 10'd900, 8'h00, 8'h00, 1'b1, 1'b0, 16'h0000);
      drain();

      kind_v = SHAPE_BOX; rel_v = REL_INSIDE; ext_v = '{10, 10, 10};
      write_all();
      offer_voxel(1'b0, 10'd50, 10'd50, 10'd50, 8'h00, 8'h00, 1'b1, 1'b0, 16'h0000);
      offer_voxel(1'b0, 10'd56, 10'd50, 10'd50, 8'h00, 8'h00, 1'b1, 1'b0, 16'h0000);
      drain();

      rel_v = REL_BELOW;
      write_all();
      offer_voxel(1'b0, 10'd50, 10'd40, 10'd50, 8'h00, 8'h00, 1'b1, 1'b0, 16'h0000);
      drain();

      rel_v = REL_NEXT_BELOW;
      write_all();
      offer_voxel(1'b0, 10'd60, 10'd50, 10'd50, 8'h00, 8'h00, 1'b1, 1'b0, 16'h0000);
      drain();

      rel_v = REL_UNDEFINED;
      write_all();
      offer_voxel(1'b0, 10'd900, 10'd3, 10'd900, 8'h00, 8'h00, 1'b1, 1'b0, 16'h0000);

      for (int ph = 0; ph < PHASES; ph++) begin
         drain();
         pick_settings(ph);
         req_idle_pct = 27;
         rsp_idle_pct = 27;
         if (ph == 5) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         // hold the result side off so the block backs up into its input
         if (ph == 8) begin
            req_idle_pct = 0;
            hold_req++;
         end
         for (int n = 0; n < PHASE_LEN; n++)
            random_voxel();
      end

      drain();
      repeat (30) @(posedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("visual_hull_voxel_classify test passed");
      else
         $display("visual_hull_voxel_classify test failed");
      $finish;
   end

endmodule
